>>> sv/teq_pkg.sv
// Shared types and constants of the timer expiry queue.
package teq_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int MAX_RESULTS    = 16;

  localparam int ID_W    = 8;
  localparam int DL_W    = 32;
  localparam int KIND_W  = 2;
  localparam int ENT_W   = ID_W + DL_W;
  localparam int NFIRE_W = $clog2(MAX_RESULTS + 1);

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_ORDER_MODE = 1'b0;
  localparam logic ORDER_MODE_RST = 1'b1;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_ADD  = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD_OK,
    KIND_ADD_FULL,
    KIND_FIRED,
    KIND_NO_EXPIRY
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_RD,
    ST_EV,
    ST_ADD_TAIL,
    ST_ADD_RESP,
    ST_TICK_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic eval;
    logic tail;
    logic resp;
    logic fin;
  } teq_cmd_t;

  typedef struct packed {
    logic is_add;
    logic full;
    logic sorted;
    logic empty;
    logic scan_last;
    logic fire;
    logic pend_v;
    logic slot_free;
  } teq_stat_t;

endpackage

>>> sv/teq_ram.sv
// Generic single write port, single read port RAM with registered read data.
module teq_ram
  #(parameter int W     = 8,
    parameter int DEPTH = 16)
  (input  logic                                       clk,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [W-1:0]                               wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [W-1:0]                               rd_data);

  logic [W-1:0] mem_r [DEPTH];
  logic [W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/teq_ctrl.sv
// Controller state machine that sequences add and tick passes over the timer table.
module teq_ctrl
  import teq_pkg::*;
  (input  logic      clk,
   input  logic      rst_n,
   input  logic      in_valid,
   output logic      in_stall,
   input  teq_stat_t stat,
   output teq_cmd_t  cmd);

  state_t state_r, state_nxt;
  logic   ev_go;

  assign ev_go = !(stat.fire && !stat.is_add && stat.pend_v && !stat.slot_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (stat.is_add) begin
          if (stat.full) state_nxt = ST_ADD_RESP;
          else if (stat.sorted && !stat.empty) state_nxt = ST_RD;
          else state_nxt = ST_ADD_TAIL;
        end else begin
          state_nxt = stat.empty ? ST_TICK_FIN : ST_RD;
        end
      end
      ST_RD: state_nxt = ST_EV;
      ST_EV: begin
        if (ev_go) begin
          if (stat.scan_last) state_nxt = stat.is_add ? ST_ADD_TAIL : ST_TICK_FIN;
          else state_nxt = ST_RD;
        end
      end
      ST_ADD_TAIL: state_nxt = ST_ADD_RESP;
      ST_ADD_RESP: begin
        if (stat.slot_free) state_nxt = ST_IDLE;
      end
      ST_TICK_FIN: begin
        if (stat.slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_RD:       cmd.rd   = 1'b1;
      ST_EV:       cmd.eval = ev_go;
      ST_ADD_TAIL: cmd.tail = 1'b1;
      ST_ADD_RESP: cmd.resp = stat.slot_free;
      ST_TICK_FIN: cmd.fin  = stat.slot_free;
      default: cmd = '0;
    endcase
  end

endmodule

>>> sv/teq_dpath.sv
// Datapath holding the timer table, tick count, scan pointers and output register.
module teq_dpath
  import teq_pkg::*;
  #(parameter int NUM_TIMERS = NUM_TIMERS_DEF)
  (input  logic             clk,
   input  logic             rst_n,
   input  logic             order_mode,
   input  logic             in_command,
   input  logic [ID_W-1:0]  in_timer_id,
   input  logic [DL_W-1:0]  in_deadline,
   input  teq_cmd_t         cmd,
   output teq_stat_t        stat,
   output logic             out_valid,
   input  logic             out_stall,
   output logic [KIND_W-1:0] out_kind,
   output logic [ID_W-1:0]  out_fired_id,
   output logic [DL_W-1:0]  out_tick_value,
   output logic             out_last);

  localparam int CW = $clog2(NUM_TIMERS + 1);
  localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  logic             cmd_r;
  logic [ID_W-1:0]  id_r;
  logic [DL_W-1:0]  dl_r;
  logic             rej_r;
  logic [DL_W-1:0]  tick_r, tick_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]    keep_r, keep_nxt;
  logic [NFIRE_W-1:0] nfire_r, nfire_nxt;
  logic             ins_r, ins_nxt;
  logic [ENT_W-1:0] carry_r, carry_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [ID_W-1:0]  pend_tag_r, pend_tag_nxt;

  logic             out_valid_r, out_valid_nxt;
  kind_t            out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]  out_id_r, out_id_nxt;
  logic [DL_W-1:0]  out_tick_r, out_tick_nxt;
  logic             out_last_r, out_last_nxt;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [ENT_W-1:0] wr_data;
  logic [ENT_W-1:0] rd_data;
  logic [DL_W-1:0]  ent_dl;
  logic [ID_W-1:0]  ent_tag;
  logic [ENT_W-1:0] new_ent;
  logic             ins_hit;
  logic             fire;
  logic             slot_free;
  logic             push;

  teq_ram #(.W(ENT_W), .DEPTH(NUM_TIMERS)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_data));

  assign ent_dl    = rd_data[DL_W-1:0];
  assign ent_tag   = rd_data[ENT_W-1:DL_W];
  assign new_ent   = {id_r, dl_r};
  assign ins_hit   = !ins_r && (dl_r <= ent_dl);
  assign fire      = (ent_dl <= tick_r) && (nfire_r < NFIRE_W'(MAX_RESULTS));
  assign slot_free = !out_valid_r || !out_stall;

  assign stat.is_add    = (cmd_r == CMD_ADD);
  assign stat.full      = (count_r == CW'(NUM_TIMERS));
  assign stat.sorted    = order_mode;
  assign stat.empty     = (count_r == '0);
  assign stat.scan_last = ((idx_r + CW'(1)) == count_r);
  assign stat.fire      = fire;
  assign stat.pend_v    = pend_v_r;
  assign stat.slot_free = slot_free;

  always_comb begin
    tick_nxt     = tick_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    keep_nxt     = keep_r;
    nfire_nxt    = nfire_r;
    ins_nxt      = ins_r;
    carry_nxt    = carry_r;
    pend_v_nxt   = pend_v_r;
    pend_tag_nxt = pend_tag_r;
    wr_en        = 1'b0;
    wr_addr      = idx_r[AW-1:0];
    wr_data      = new_ent;
    push         = 1'b0;
    out_kind_nxt = out_kind_r;
    out_id_nxt   = out_id_r;
    out_tick_nxt = out_tick_r;
    out_last_nxt = out_last_r;

    if (cmd.load) begin
      if (in_command == CMD_TICK) begin
        tick_nxt = tick_r + DL_W'(1);
      end
      idx_nxt    = '0;
      keep_nxt   = '0;
      nfire_nxt  = '0;
      ins_nxt    = 1'b0;
      pend_v_nxt = 1'b0;
    end

    if (cmd.eval) begin
      idx_nxt = idx_r + CW'(1);
      if (cmd_r == CMD_ADD) begin
        if (ins_hit) begin
          wr_en     = 1'b1;
          wr_data   = new_ent;
          carry_nxt = rd_data;
          ins_nxt   = 1'b1;
        end else if (ins_r) begin
          wr_en     = 1'b1;
          wr_data   = carry_r;
          carry_nxt = rd_data;
        end
      end else if (fire) begin
        if (pend_v_r) begin
          push         = 1'b1;
          out_kind_nxt = KIND_FIRED;
          out_id_nxt   = pend_tag_r;
          out_tick_nxt = tick_r;
          out_last_nxt = 1'b0;
        end
        pend_v_nxt   = 1'b1;
        pend_tag_nxt = ent_tag;
        nfire_nxt    = nfire_r + NFIRE_W'(1);
      end else begin
        wr_en    = 1'b1;
        wr_addr  = keep_r[AW-1:0];
        wr_data  = rd_data;
        keep_nxt = keep_r + CW'(1);
      end
    end

    if (cmd.tail) begin
      wr_en     = 1'b1;
      wr_addr   = count_r[AW-1:0];
      wr_data   = ins_r ? carry_r : new_ent;
      count_nxt = count_r + CW'(1);
    end

    if (cmd.resp) begin
      push         = 1'b1;
      out_tick_nxt = tick_r;
      out_last_nxt = 1'b1;
      if (rej_r) begin
        out_kind_nxt = KIND_ADD_FULL;
        out_id_nxt   = '0;
      end else begin
        out_kind_nxt = KIND_ADD_OK;
        out_id_nxt   = id_r;
      end
    end

    if (cmd.fin) begin
      push         = 1'b1;
      count_nxt    = keep_r;
      out_tick_nxt = tick_r;
      out_last_nxt = 1'b1;
      if (pend_v_r) begin
        out_kind_nxt = KIND_FIRED;
        out_id_nxt   = pend_tag_r;
      end else begin
        out_kind_nxt = KIND_NO_EXPIRY;
        out_id_nxt   = '0;
      end
    end

    out_valid_nxt = push || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      keep_r      <= '0;
      nfire_r     <= '0;
      ins_r       <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tick_r      <= tick_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      keep_r      <= keep_nxt;
      nfire_r     <= nfire_nxt;
      ins_r       <= ins_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_command;
      id_r  <= in_timer_id;
      dl_r  <= in_deadline;
      rej_r <= (count_r == CW'(NUM_TIMERS));
    end
    carry_r    <= carry_nxt;
    pend_tag_r <= pend_tag_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_tick_r <= out_tick_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_fired_id   = out_id_r;
  assign out_tick_value = out_tick_r;
  assign out_last       = out_last_r;

endmodule

>>> sv/timer_expiry_queue_core.sv
// Top level of the timer expiry queue: configuration register, controller and datapath.
//
// The input channel takes one word per command: a tick (in_command = 0) or an add of
// timer in_timer_id with absolute deadline in_deadline (in_command = 1). The output
// channel returns one word per result; out_last marks the final word of a command.
// A tick returns one word per fired timer, or a single no-expiry word. An add returns
// one acknowledge or table-full word. One command is processed at a time.
// An add in plain mode or into an empty table writes the new entry at the tail with no
// scan; a sorted add and a tick scan all N stored timers, each entry being read and then
// evaluated through the single read port of the table RAM. A new command is accepted
// the cycle after the last result is loaded into the output register, even while that
// word still waits. When the receiver stalls, the output word holds and the scan pauses
// at the next entry that needs an output slot. Reset empties the table, clears the tick
// count and sets order_mode to sorted; table contents are not cleared. The order_mode
// register answers at byte addresses 0 to 3 of the configuration port.
module timer_expiry_queue_core
  import teq_pkg::*;
  #(parameter int NUM_TIMERS = NUM_TIMERS_DEF)
  (input  logic               clk,
   input  logic               rst_n,
   input  logic               in_valid,
   output logic               in_stall,
   input  logic               in_command,
   input  logic [ID_W-1:0]    in_timer_id,
   input  logic [DL_W-1:0]    in_deadline,
   output logic               out_valid,
   input  logic               out_stall,
   output logic [KIND_W-1:0]  out_kind,
   output logic [ID_W-1:0]    out_fired_id,
   output logic [DL_W-1:0]    out_tick_value,
   output logic               out_last,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready);

  logic      order_mode_r;
  logic      cfg_wr;
  teq_cmd_t  cmd;
  teq_stat_t stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_ORDER_MODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_mode_r <= ORDER_MODE_RST;
    end else if (cfg_wr) begin
      order_mode_r <= pwdata[0];
    end
  end

  assign prdata = (paddr[PADDR_W-1] == REG_ORDER_MODE) ?
                  {{(PDATA_W-1){1'b0}}, order_mode_r} : '0;

  teq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd));

  teq_dpath #(.NUM_TIMERS(NUM_TIMERS)) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .order_mode     (order_mode_r),
    .in_command     (in_command),
    .in_timer_id    (in_timer_id),
    .in_deadline    (in_deadline),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_fired_id   (out_fired_id),
    .out_tick_value (out_tick_value),
    .out_last       (out_last));

endmodule

>>> sv/teq_checker.sv
// Port-level checker for the timer expiry queue and its bind to the top level.
module teq_checker
  import teq_pkg::*;
  (input logic              clk,
   input logic              rst_n,
   input logic              in_valid,
   input logic              in_stall,
   input logic              out_valid,
   input logic              out_stall,
   input logic [KIND_W-1:0] out_kind,
   input logic [ID_W-1:0]   out_fired_id,
   input logic [DL_W-1:0]   out_tick_value,
   input logic              out_last);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_fired_id)
                               && $stable(out_tick_value) && $stable(out_last))
    else $error("stalled output word changed");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_FIRED) |-> out_last)
    else $error("add or no-expiry word without last");

  a_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_kind == KIND_ADD_FULL) || (out_kind == KIND_NO_EXPIRY))
    |-> (out_fired_id == '0))
    else $error("nonzero tag on full or no-expiry word");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while busy");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind timer_expiry_queue_core teq_checker u_teq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_kind       (out_kind),
  .out_fired_id   (out_fired_id),
  .out_tick_value (out_tick_value),
  .out_last       (out_last));
